/* sv/hex_md_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_md_pkg
// Shared payload types and fixed constants for the hexagonal torus
// minimum-image distance pipeline.
// ----------------------------------------------------------------------------
package hex_md_pkg;

  // One pair of lattice sites, each row * SIDE + column
  typedef struct packed {
    logic [15:0] site_a;
    logic [15:0] site_b;
  } in_item_t;

  // Distance result: squared steps, Q8.8 root, Q12.8 scaled distance
  typedef struct packed {
    logic [15:0] squared_steps;
    logic [15:0] root_steps;
    logic [19:0] scaled_distance;
  } out_item_t;

  // Bond length after reset: 0.44 in unsigned Q4.12, truncated
  localparam logic [15:0] BOND_RESET = 16'd1802;

  // Ceiling of the squared step count
  localparam logic [15:0] SQ_MAX = 16'hFFFF;

endpackage

/* sv/hex_torus_min_image_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_torus_min_image_distance
// Minimum-image squared distance, its root and its scaled length between
// two sites of a periodic hexagonal lattice, one pair per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready channel, one site pair per transfer (in_data).
//   out_*  : valid/ready channel, one distance result per input transfer.
//   cfg_*  : valid/ready write channel for bond_length (Q4.12); cfg_ready is
//            always high. Write it only while no pair is in flight.
//   Throughput: one pair per cycle unless the output stalls. The path is a
//            19-register pipeline: a reciprocal multiply and a correction per
//            site split (column and row), coordinate difference, image products,
//            sum, two-level minimum, eight radix-4 square root stages, one
//            bond-length multiply and the output register.
//   Stall: the whole pipeline holds while the output register is full and
//            out_ready is low; in_ready drops in the same cycle. Nothing is
//            lost or repeated.
//   Reset: rst (synchronous) empties the pipeline and loads the default bond
//            length of 0.44.
// ----------------------------------------------------------------------------
module hex_torus_min_image_distance #(
  parameter int SIDE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hex_md_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hex_md_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);

  localparam int CW  = $clog2(SIDE);              // column / row width
  localparam int QW  = $clog2(65536 / SIDE + 1);  // site quotient width
  localparam int IW  = CW + 2;                    // image coordinate width
  localparam int PW  = 2 * IW;                    // product / quadratic width
  localparam int SW  = PW + 1;                    // signed sum width
  localparam int NST = 19;                        // pipeline register stages
  localparam int NSQ = 8;                         // square root stages

  // floor(2^32 / SIDE): the estimate is at most one below the true quotient
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SIDE);

  localparam logic signed [IW-1:0] SIDE_S = IW'(SIDE);
  localparam logic signed [IW-1:0] OFF [3] = '{-SIDE_S, '0, SIDE_S};

  typedef struct packed {
    logic [QW-1:0] quo;
    logic [CW-1:0] rmd;
  } divfix_t;

  typedef struct packed {
    logic [15:0] sq;
    logic [31:0] rad;
    logic [16:0] rem;
    logic [15:0] root;
  } sqrt_t;

  // Correct a reciprocal quotient estimate with one compare and subtract
  function automatic divfix_t div_fix(input logic [15:0] num, input logic [47:0] prod);
    logic [QW-1:0] est;
    logic [16:0]   rmd;
    divfix_t       res;
    est = prod[32 +: QW];
    rmd = {1'b0, num} - 17'(est * SIDE);
    if (rmd >= 17'(SIDE)) begin
      res.quo = est + QW'(1);
      res.rmd = CW'(rmd - 17'(SIDE));
    end else begin
      res.quo = est;
      res.rmd = CW'(rmd);
    end
    return res;
  endfunction

  function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  // One radix-4 digit of the integer square root recurrence
  function automatic sqrt_t sqrt_step(input sqrt_t st);
    logic [18:0] rsh;
    logic [18:0] trial;
    sqrt_t       nx;
    nx    = st;
    rsh   = {st.rem, st.rad[31:30]};
    trial = {1'b0, st.root, 2'b01};
    if (rsh >= trial) begin
      nx.rem  = 17'(rsh - trial);
      nx.root = {st.root[14:0], 1'b1};
    end else begin
      nx.rem  = 17'(rsh);
      nx.root = {st.root[14:0], 1'b0};
    end
    nx.rad = {st.rad[29:0], 2'b00};
    return nx;
  endfunction

  logic [NST-1:0] vld;
  logic           adv;
  logic [15:0]    bond_length;

  logic [15:0]    s1_a, s1_b;
  logic [47:0]    s1_pa, s1_pb;
  logic [CW-1:0]  s2_ca, s2_cb;
  logic [QW-1:0]  s2_qa, s2_qb;
  logic [CW-1:0]  s3_ca, s3_cb;
  logic [QW-1:0]  s3_qa, s3_qb;
  logic [47:0]    s3_pa, s3_pb;
  logic [CW-1:0]  s4_ca, s4_cb, s4_ra, s4_rb;
  logic signed [CW:0]    s5_dx, s5_dy;
  logic signed [PW-1:0]  s6_xx [3];
  logic signed [PW-1:0]  s6_yy [3];
  logic signed [PW-1:0]  s6_xy [9];
  logic [PW-1:0]  s7_quad [9];
  logic [PW-1:0]  s8_min [3];
  logic [15:0]    s9_sq;
  sqrt_t          sq_pipe [NSQ];
  logic [15:0]    s18_sq, s18_root;
  logic [31:0]    s18_prod;

  divfix_t        fix_a, fix_b, fix_ra, fix_rb;
  logic signed [IW-1:0] img_x [3];
  logic signed [IW-1:0] img_y [3];
  logic signed [SW-1:0] quad_sum [9];
  logic [PW-1:0]  min_all;
  sqrt_t          sq_seed;

  // Advance the pipeline unless the output register holds an untaken result
  assign adv       = !vld[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NST-1];
  assign cfg_ready = 1'b1;

  // Hold the bond length register
  always_ff @(posedge clk) begin
    if (rst) begin
      bond_length <= hex_md_pkg::BOND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bond_length <= cfg_data;
    end
  end

  // Shift valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Correct quotients, form image coordinates, quadratic sums, the overall minimum and the root seed
  always_comb begin
    fix_a  = div_fix(s1_a, s1_pa);
    fix_b  = div_fix(s1_b, s1_pb);
    fix_ra = div_fix(16'(s3_qa), s3_pa);
    fix_rb = div_fix(16'(s3_qb), s3_pb);
    for (int k = 0; k < 3; k++) begin
      img_x[k] = IW'(s5_dx) + OFF[k];
      img_y[k] = IW'(s5_dy) + OFF[k];
    end
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        quad_sum[3*k+l] = SW'(s6_xx[k]) + SW'(s6_xy[3*k+l]) + SW'(s6_yy[l]);
      end
    end
    min_all = min2(min2(s8_min[0], s8_min[1]), s8_min[2]);
    sq_seed.sq   = s9_sq;
    sq_seed.rad  = {s9_sq, 16'h0000};
    sq_seed.rem  = '0;
    sq_seed.root = '0;
  end

  // Split sites into column and row, then form the nine image quadratics and their saturated minimum
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a  <= in_data.site_a;
      s1_b  <= in_data.site_b;
      s1_pa <= 48'(in_data.site_a) * 48'(RECIP);
      s1_pb <= 48'(in_data.site_b) * 48'(RECIP);

      s2_ca <= fix_a.rmd;
      s2_cb <= fix_b.rmd;
      s2_qa <= fix_a.quo;
      s2_qb <= fix_b.quo;

      s3_ca <= s2_ca;
      s3_cb <= s2_cb;
      s3_qa <= s2_qa;
      s3_qb <= s2_qb;
      s3_pa <= 48'(s2_qa) * 48'(RECIP);
      s3_pb <= 48'(s2_qb) * 48'(RECIP);

      s4_ca <= s3_ca;
      s4_cb <= s3_cb;
      s4_ra <= fix_ra.rmd;
      s4_rb <= fix_rb.rmd;

      s5_dx <= $signed({1'b0, s4_ca}) - $signed({1'b0, s4_cb});
      s5_dy <= $signed({1'b0, s4_ra}) - $signed({1'b0, s4_rb});

      for (int k = 0; k < 3; k++) begin
        s6_xx[k] <= img_x[k] * img_x[k];
        s6_yy[k] <= img_y[k] * img_y[k];
        for (int l = 0; l < 3; l++) begin
          s6_xy[3*k+l] <= img_x[k] * img_y[l];
        end
      end

      for (int i = 0; i < 9; i++) begin
        s7_quad[i] <= PW'(quad_sum[i]);
      end

      for (int i = 0; i < 3; i++) begin
        s8_min[i] <= min2(min2(s7_quad[3*i], s7_quad[3*i+1]), s7_quad[3*i+2]);
      end

      // Saturate the minimum to the 16-bit result range
      if (32'(min_all) > 32'(hex_md_pkg::SQ_MAX)) begin
        s9_sq <= hex_md_pkg::SQ_MAX;
      end else begin
        s9_sq <= 16'(min_all);
      end
    end
  end

  // Take the Q8.8 root two digits per stage, then scale by the bond length
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pipe[0] <= sqrt_step(sqrt_step(sq_seed));
      for (int j = 1; j < NSQ; j++) begin
        sq_pipe[j] <= sqrt_step(sqrt_step(sq_pipe[j-1]));
      end

      s18_sq   <= sq_pipe[NSQ-1].sq;
      s18_root <= sq_pipe[NSQ-1].root;
      s18_prod <= 32'(sq_pipe[NSQ-1].root) * 32'(bond_length);

      // Product of two 16-bit values shifted by 12 always fits 20 bits
      out_data.squared_steps   <= s18_sq;
      out_data.root_steps      <= s18_root;
      out_data.scaled_distance <= s18_prod[31:12];
    end
  end

  // Root is the floor square root of the squared steps in Q8.8
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (34'(out_data.root_steps) * 34'(out_data.root_steps)
                   <= 34'({out_data.squared_steps, 16'h0000})) &&
                  ((34'(out_data.root_steps) + 34'd1) * (34'(out_data.root_steps) + 34'd1)
                   > 34'({out_data.squared_steps, 16'h0000})))
    else $error("root_steps is not the floor root of squared_steps");

  // Zero distance and zero root go together
  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.squared_steps == 16'd0) == (out_data.root_steps == 16'd0)))
    else $error("zero squared_steps and zero root_steps disagree");

  // Split coordinates stay on the torus
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (32'(s4_ca) < SIDE) && (32'(s4_cb) < SIDE) &&
               (32'(s4_ra) < SIDE) && (32'(s4_rb) < SIDE))
    else $error("column or row outside the lattice");

  // A stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule
